FILE: design/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the six-byte UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CodeW    = 31;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW     = $clog2(FifoDepth);
  localparam int unsigned CntW     = $clog2(FifoDepth + 1);

  localparam logic [CodeW-1:0] UndefCodeReset = 31'd65533;

  // result status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic [1:0]       status;
    logic             run_last;
  } out_item_t;

  // sequence tracking state
  typedef struct packed {
    logic [CodeW-1:0] partial_value;
    logic [2:0]       bytes_left;
    logic [2:0]       sequence_length;
  } seq_state_t;

  // up to two results from one byte, in order
  typedef struct packed {
    out_item_t  res0;
    out_item_t  res1;
    logic [1:0] cnt;
  } dec_out_t;

endpackage

FILE: design/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Six-byte legacy UTF-8 decoder for a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless stalled and decoded in the cycle it is
// accepted; its results (none, one or two) enter a four-entry result queue
// and reach the output in the next cycle at the earliest, one result per
// clock unless the output stalls. A byte breaking an open sequence can yield
// two results, but that sequence was opened by a byte with no result and no
// such byte follows right after, so with a ready receiver the queue never
// holds more than two results and input runs at one byte per cycle. The input
// stalls while over two results are queued, which only output stalls cause.
// undefined_code may only be written while idle.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [u8d_pkg::CodeW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  u8d_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output u8d_pkg::out_item_t        out_item_o
);

  logic [u8d_pkg::CodeW-1:0] undef_code_q;
  u8d_pkg::seq_state_t       state_q, state_d;
  u8d_pkg::dec_out_t         dec;
  logic                      in_accept;
  logic                      fifo_full;

  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i && !fifo_full;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      undef_code_q <= u8d_pkg::UndefCodeReset;
    end else if (cfg_we_i) begin
      undef_code_q <= cfg_wdata_i;
    end
  end

  // byte decode
  u8d_decode u_decode (
    .in_item_i    (in_item_i),
    .state_i      (state_q),
    .undef_code_i (undef_code_q),
    .state_o      (state_d),
    .dec_o        (dec)
  );

  // sequence state, advanced on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // result queue
  u8d_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (in_accept),
    .dec_i       (dec),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: design/u8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_decode
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  u8d_pkg::in_item_t         in_item_i,
  input  u8d_pkg::seq_state_t       state_i,
  input  logic [u8d_pkg::CodeW-1:0] undef_code_i,
  output u8d_pkg::seq_state_t       state_o,
  output u8d_pkg::dec_out_t         dec_o
);

  logic [7:0]              b;
  logic                    last;
  logic                    lead_emit;
  u8d_pkg::out_item_t      lead_res;
  u8d_pkg::seq_state_t     lead_st;
  logic [2:0]              lead_len;
  logic [7:0]              lead_pay;
  u8d_pkg::out_item_t      undef_res;
  u8d_pkg::out_item_t      trunc_res;
  logic [u8d_pkg::CodeW-1:0] pv_next;
  logic [2:0]              bl_next;
  logic [2:0]              form_len;

  assign b    = in_item_i.in_byte;
  assign last = in_item_i.last_byte;

  always_comb begin
    undef_res.code_point = undef_code_i;
    undef_res.status     = u8d_pkg::ST_UNDEF;
    undef_res.run_last   = 1'b0;
    trunc_res.code_point = '0;
    trunc_res.status     = u8d_pkg::ST_TRUNC;
    trunc_res.run_last   = 1'b0;
  end

  // byte taken as a lead
  always_comb begin
    lead_emit = 1'b1;
    lead_res  = undef_res;
    lead_st   = '0;
    lead_len  = 3'd0;
    lead_pay  = 8'h00;
    if (b == 8'h00) begin
      lead_res = undef_res;
    end else if (!b[7]) begin
      lead_res.code_point = {23'd0, b};
      lead_res.status     = u8d_pkg::ST_VALID;
      lead_res.run_last   = 1'b0;
    end else if (b[7:6] == 2'b10) begin
      lead_res = undef_res;
    end else begin
      if (b[7:5] == 3'b110) begin
        lead_len = 3'd2;
        lead_pay = b & 8'h1F;
      end else if (b[7:4] == 4'b1110) begin
        lead_len = 3'd3;
        lead_pay = b & 8'h0F;
      end else if (b[7:3] == 5'b11110) begin
        lead_len = 3'd4;
        lead_pay = b & 8'h07;
      end else if (b[7:2] == 6'b111110) begin
        lead_len = 3'd5;
        lead_pay = b & 8'h03;
      end else if (b[7:1] == 7'b1111110) begin
        lead_len = 3'd6;
        lead_pay = b & 8'h01;
      end
      // 0xFE and 0xFF leave the length at zero and give the undefined code
      if (lead_len != 3'd0) begin
        if (last) begin
          lead_res = trunc_res;
        end else begin
          lead_emit                = 1'b0;
          lead_st.partial_value    = {23'd0, lead_pay};
          lead_st.bytes_left       = lead_len - 3'd1;
          lead_st.sequence_length  = lead_len;
        end
      end
    end
  end

  // continuation byte accumulation and shortest-form length
  assign pv_next = {state_i.partial_value[u8d_pkg::CodeW-7:0], b[5:0]};
  assign bl_next = state_i.bytes_left - 3'd1;

  always_comb begin
    if (pv_next <= 31'h7F)           form_len = 3'd1;
    else if (pv_next <= 31'h7FF)     form_len = 3'd2;
    else if (pv_next <= 31'hFFFF)    form_len = 3'd3;
    else if (pv_next <= 31'h1FFFFF)  form_len = 3'd4;
    else if (pv_next <= 31'h3FFFFFF) form_len = 3'd5;
    else                             form_len = 3'd6;
  end

  // main decision
  always_comb begin
    dec_o.res0 = undef_res;
    dec_o.res1 = undef_res;
    dec_o.cnt  = 2'd0;
    state_o    = '0;
    if (state_i.bytes_left == 3'd0) begin
      dec_o.res0 = lead_res;
      dec_o.cnt  = {1'b0, lead_emit};
      state_o    = lead_st;
    end else if (b == 8'h00) begin
      dec_o.cnt = 2'd1;
    end else if (b[7:6] != 2'b10) begin
      // missing continuation: drop the sequence, then retry as a lead
      dec_o.res1 = lead_res;
      dec_o.cnt  = lead_emit ? 2'd2 : 2'd1;
      state_o    = lead_st;
    end else if (bl_next == 3'd0) begin
      if (form_len == state_i.sequence_length) begin
        dec_o.res0.code_point = pv_next;
        dec_o.res0.status     = u8d_pkg::ST_VALID;
      end
      dec_o.cnt = 2'd1;
    end else if (last) begin
      dec_o.res0 = trunc_res;
      dec_o.cnt  = 2'd1;
    end else begin
      state_o.partial_value   = pv_next;
      state_o.bytes_left      = bl_next;
      state_o.sequence_length = state_i.sequence_length;
    end
    if (last) begin
      state_o = '0;
    end
    // mark the final result of this byte
    if (dec_o.cnt == 2'd2) begin
      dec_o.res1.run_last = 1'b1;
    end else if (dec_o.cnt == 2'd1) begin
      dec_o.res0.run_last = 1'b1;
    end
  end

endmodule

FILE: design/u8d_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_out_fifo
// Result queue: takes up to two results a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module u8d_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_en_i,
  input  u8d_pkg::dec_out_t  dec_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u8d_pkg::out_item_t out_item_o
);

  u8d_pkg::out_item_t           mem_q [u8d_pkg::FifoDepth];
  logic [u8d_pkg::PtrW-1:0]     wr_q, wr_d;
  logic [u8d_pkg::PtrW-1:0]     rd_q, rd_d;
  logic [u8d_pkg::CntW-1:0]     count_q, count_d;
  logic [u8d_pkg::PtrW-1:0]     wr_next;
  logic [1:0]                   push_cnt;
  logic                         pop;

  assign push_cnt = push_en_i ? dec_i.cnt : 2'd0;
  assign pop      = out_valid_o && !out_stall_i;
  assign wr_next  = wr_q + u8d_pkg::PtrW'(1);

  // room for a full two-result push is kept at all times
  assign full_o      = count_q > u8d_pkg::CntW'(u8d_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rd_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_d    = wr_q + u8d_pkg::PtrW'(push_cnt);
    rd_d    = pop ? rd_q + u8d_pkg::PtrW'(1) : rd_q;
    count_d = count_q + u8d_pkg::CntW'(push_cnt) - u8d_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      mem_q[wr_q] <= dec_i.res0;
    end
    if (push_cnt == 2'd2) begin
      mem_q[wr_next] <= dec_i.res1;
    end
  end

endmodule

FILE: design/u8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input u8d_pkg::out_item_t out_item_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // status is one of the three defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != 2'd3)
    else $error("unknown status code");

  // a truncation result carries code zero and ends its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == u8d_pkg::ST_TRUNC
      |-> out_item_o.code_point == '0 && out_item_o.run_last)
    else $error("malformed truncation result");

  // no result appears without a transaction on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result without input");

endmodule

bind utf8_stream_decoder_unit u8d_checker u_u8d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
